// ===== rtl/bsfb_pkg.sv =====
package bsfb_pkg;

   localparam logic [7:0] FLAG_BYTE  = 8'h7E;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] ESC_FLAG   = 8'h5E;
   localparam logic [7:0] ESC_ESC    = 8'h5D;
   localparam logic [7:0] CTRL_NS0   = 8'h00;
   localparam logic [7:0] CTRL_NS1   = 8'h40;
   localparam logic [7:0] ADDR_RESET = 8'h03;

   // One classified payload word, as handed from the front end to the back end.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       hdr;
      logic       seq;
      logic [7:0] addr;
      logic [7:0] bcc2;
   } entry_type;

   typedef enum logic [3:0] {
      S_FLAG,
      S_ADDR,
      S_CTRL,
      S_BCC1,
      S_DATA,
      S_DATA_ESC,
      S_BCC2,
      S_BCC2_ESC,
      S_CLOSE
   } step_type;

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

   function automatic logic [7:0] escape_code(input logic [7:0] b);
      return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
   endfunction

endpackage

// ===== rtl/bsfb_front.sv =====
module bsfb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [7:0]            csr_address_byte,
   input  logic                  push,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   input  logic                  sequence_bit,
   output bsfb_pkg::entry_type   entry
);

   logic       inside_frame_ff, inside_frame_in;
   logic [7:0] parity_ff, parity_in;
   logic [7:0] address_ff;
   logic [7:0] parity_new;

   // The parity restarts with every new frame, so a frame's first word sees zero.
   assign parity_new = (inside_frame_ff ? parity_ff : 8'h00) ^ data_byte;

   always_comb begin
      entry.data = data_byte;
      entry.last = last_byte;
      entry.hdr  = !inside_frame_ff;
      entry.seq  = sequence_bit;
      entry.addr = address_ff;
      entry.bcc2 = parity_new;
   end

   always_comb begin
      inside_frame_in = inside_frame_ff;
      parity_in       = parity_ff;
      if (push) begin
         inside_frame_in = !last_byte;
         parity_in       = last_byte ? 8'h00 : parity_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_frame_ff <= 1'b0;
         parity_ff       <= 8'h00;
         address_ff      <= bsfb_pkg::ADDR_RESET;
      end else begin
         inside_frame_ff <= inside_frame_in;
         parity_ff       <= parity_in;
         if (csr_valid) begin
            address_ff <= csr_address_byte;
         end
      end
   end

endmodule

// ===== rtl/bsfb_queue.sv =====
module bsfb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bsfb_pkg::entry_type   push_entry,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output bsfb_pkg::entry_type   head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bsfb_pkg::entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

endmodule

// ===== rtl/bsfb_back.sv =====
module bsfb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  bsfb_pkg::entry_type   head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_line_byte,
   output logic                  rsp_frame_end
);

   bsfb_pkg::step_type step_ff, step_in, step_cur, step_next;
   logic       word_done;
   logic       load;
   logic [7:0] ctrl;
   logic [7:0] byte_out;
   logic       end_out;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] line_byte_ff;
   logic       frame_end_ff;

   assign ctrl = head.seq ? bsfb_pkg::CTRL_NS1 : bsfb_pkg::CTRL_NS0;

   // A word without a header starts straight at its payload byte.
   assign step_cur = (step_ff == bsfb_pkg::S_FLAG && !head.hdr) ? bsfb_pkg::S_DATA : step_ff;

   // The output register takes a byte whenever it is empty or being drained.
   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && word_done;

   // Next step within the current word.
   always_comb begin
      step_next = bsfb_pkg::S_FLAG;
      word_done = 1'b0;
      unique case (step_cur)
         bsfb_pkg::S_FLAG: step_next = bsfb_pkg::S_ADDR;
         bsfb_pkg::S_ADDR: step_next = bsfb_pkg::S_CTRL;
         bsfb_pkg::S_CTRL: step_next = bsfb_pkg::S_BCC1;
         bsfb_pkg::S_BCC1: step_next = bsfb_pkg::S_DATA;
         bsfb_pkg::S_DATA: begin
            if (bsfb_pkg::needs_escape(head.data)) begin
               step_next = bsfb_pkg::S_DATA_ESC;
            end else if (head.last) begin
               step_next = bsfb_pkg::S_BCC2;
            end else begin
               word_done = 1'b1;
            end
         end
         bsfb_pkg::S_DATA_ESC: begin
            if (head.last) begin
               step_next = bsfb_pkg::S_BCC2;
            end else begin
               word_done = 1'b1;
            end
         end
         bsfb_pkg::S_BCC2: begin
            step_next = bsfb_pkg::needs_escape(head.bcc2) ? bsfb_pkg::S_BCC2_ESC
                                                          : bsfb_pkg::S_CLOSE;
         end
         bsfb_pkg::S_BCC2_ESC: step_next = bsfb_pkg::S_CLOSE;
         bsfb_pkg::S_CLOSE: word_done = 1'b1;
         default: word_done = 1'b1;
      endcase
   end

   // Byte produced at the current step.
   always_comb begin
      byte_out = bsfb_pkg::FLAG_BYTE;
      end_out  = 1'b0;
      unique case (step_cur)
         bsfb_pkg::S_FLAG:     byte_out = bsfb_pkg::FLAG_BYTE;
         bsfb_pkg::S_ADDR:     byte_out = head.addr;
         bsfb_pkg::S_CTRL:     byte_out = ctrl;
         bsfb_pkg::S_BCC1:     byte_out = head.addr ^ ctrl;
         bsfb_pkg::S_DATA: begin
            byte_out = bsfb_pkg::needs_escape(head.data) ? bsfb_pkg::ESC_BYTE : head.data;
         end
         bsfb_pkg::S_DATA_ESC: byte_out = bsfb_pkg::escape_code(head.data);
         bsfb_pkg::S_BCC2: begin
            byte_out = bsfb_pkg::needs_escape(head.bcc2) ? bsfb_pkg::ESC_BYTE : head.bcc2;
         end
         bsfb_pkg::S_BCC2_ESC: byte_out = bsfb_pkg::escape_code(head.bcc2);
         bsfb_pkg::S_CLOSE: begin
            byte_out = bsfb_pkg::FLAG_BYTE;
            end_out  = 1'b1;
         end
         default: byte_out = bsfb_pkg::FLAG_BYTE;
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in = head_valid;
      end
      if (load) begin
         step_in = word_done ? bsfb_pkg::S_FLAG : step_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= bsfb_pkg::S_FLAG;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         line_byte_ff <= byte_out;
         frame_end_ff <= end_out;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_line_byte = line_byte_ff;
   assign rsp_frame_end = frame_end_ff;

   a_end_is_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> (rsp_line_byte == bsfb_pkg::FLAG_BYTE))
      else $error("frame end marked on a byte other than the flag");

   a_mid_word_has_head: assert property (@(posedge clock) disable iff (reset)
      (step_ff != bsfb_pkg::S_FLAG) |-> head_valid)
      else $error("sequencer part-way through a word with the queue empty");

endmodule

// ===== rtl/byte_stuffed_info_frame_builder_unit.sv =====
// An accepted word passes through the queue and the output register. Throughput: one
// line byte per cycle from the back-end sequencer unless rsp_stall holds it, so a
// word gives 1 to 9 bytes: 4 header bytes on a frame's first word, 1 or 2 for the
// payload byte, and 2 to 3 more (BCC2, escape, closing flag) on the last word.
// Reset (synchronous): no frame open, parity cleared, address 0x03, queue and output empty.
module byte_stuffed_info_frame_builder_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_address_byte,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       req_sequence_bit,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_line_byte,
   output logic       rsp_frame_end
);

   bsfb_pkg::entry_type push_entry, head;
   logic push, pop, full, head_valid;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign push      = req_valid && !full;

   bsfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_address_byte (csr_address_byte),
      .push             (push),
      .data_byte        (req_data_byte),
      .last_byte        (req_last_byte),
      .sequence_bit     (req_sequence_bit),
      .entry            (push_entry)
   );

   bsfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head       (head)
   );

   bsfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_line_byte (rsp_line_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 150;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_WAIT     = 10;
   localparam int RANDOM_WORDS = 46;
   localparam int RANDOM_PHASES = 8;
   localparam int PRESSURE_PHASE = 3;
   localparam int PRINT_LIMIT  = 40;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       seq;
   } payload_word_type;

   typedef struct {
      logic [7:0] line;
      logic       fend;
   } line_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_address_byte = 8'h00;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       req_sequence_bit = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_line_byte;
   logic       rsp_frame_end;

   logic rsp_wait  = 1'b0;
   logic line_hold = 1'b0;
   logic hold_go   = 1'b0;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   payload_word_type pending[$];
   line_word_type    line_expect[$];

   int req_gap = 0;
   int req_max_gap = 0;
   int rsp_gap = 0;
   int rsp_max_gap = 0;
   int error_count = 0;
   int cycle_count = 0;

   // Predictor state, kept in step with the block.
   logic       frame_open = 1'b0;
   logic [7:0] payload_xor = 8'h00;
   logic [7:0] link_address = bsfb_pkg::ADDR_RESET;

   assign rsp_stall = rsp_wait | line_hold;

   byte_stuffed_info_frame_builder_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_address_byte (csr_address_byte),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_sequence_bit (req_sequence_bit),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_frame_end    (rsp_frame_end)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      error_count++;
   endtask

   task automatic push_line(input logic [7:0] b, input logic fend);
      line_word_type w;
      w.line = b;
      w.fend = fend;
      line_expect.push_back(w);
   endtask

   task automatic push_stuffed(input logic [7:0] b);
      if (b == bsfb_pkg::FLAG_BYTE || b == bsfb_pkg::ESC_BYTE) begin
         push_line(bsfb_pkg::ESC_BYTE, 1'b0);
         push_line((b == bsfb_pkg::FLAG_BYTE) ? bsfb_pkg::ESC_FLAG : bsfb_pkg::ESC_ESC, 1'b0);
      end else begin
         push_line(b, 1'b0);
      end
   endtask

   task automatic expect_line_bytes(input logic [7:0] data, input logic last,
                                    input logic seq);
      logic [7:0] ctrl;
      if (!frame_open) begin
         ctrl = seq ? bsfb_pkg::CTRL_NS1 : bsfb_pkg::CTRL_NS0;
         push_line(bsfb_pkg::FLAG_BYTE, 1'b0);
         push_line(link_address, 1'b0);
         push_line(ctrl, 1'b0);
         push_line(link_address ^ ctrl, 1'b0);
         payload_xor = 8'h00;
         frame_open  = 1'b1;
      end
      push_stuffed(data);
      payload_xor = payload_xor ^ data;
      if (last) begin
         push_stuffed(payload_xor);
         push_line(bsfb_pkg::FLAG_BYTE, 1'b1);
         frame_open  = 1'b0;
         payload_xor = 8'h00;
      end
   endtask

   // Sender: a word is held until taken, then the drawn gap runs out before the next.
   always @(negedge clock) begin : word_driver
      payload_word_type w;
      logic drive;
      if (!req_valid || req_taken) begin
         drive = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending.size() > 0) begin
            w = pending.pop_front();
            req_data_byte    <= w.data;
            req_last_byte    <= w.last;
            req_sequence_bit <= w.seq;
            drive = 1'b1;
            req_gap = $urandom_range(0, req_max_gap);
         end
         req_valid <= drive;
      end
   end

   always @(negedge clock) begin : line_receiver
      if (rsp_taken) begin
         rsp_gap = $urandom_range(0, rsp_max_gap);
      end
      if (rsp_gap > 0) begin
         rsp_wait <= 1'b1;
         rsp_gap--;
      end else begin
         rsp_wait <= 1'b0;
      end
   end

   // One long hold-off on the line side, so that the block backs up into its input.
   initial begin : receiver_hold
      wait (hold_go);
      @(negedge clock) line_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      line_hold <= 1'b0;
   end

   always @(posedge clock) begin : line_monitor
      line_word_type w;
      req_taken <= req_valid && !req_stall && !reset;
      rsp_taken <= rsp_valid && !rsp_stall && !reset;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else if (!reset) begin
         if (csr_valid && csr_ready) begin
            link_address = csr_address_byte;
         end
         if (req_valid && !req_stall) begin
            expect_line_bytes(req_data_byte, req_last_byte, req_sequence_bit);
         end
         if (rsp_valid && !rsp_stall) begin
            if (line_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected line byte %02h end %0b",
                                         rsp_line_byte, rsp_frame_end));
            end else begin
               w = line_expect.pop_front();
               if (rsp_line_byte !== w.line) begin
                  report_mismatch($sformatf("line_byte %02h, expected %02h",
                                            rsp_line_byte, w.line));
               end
               if (rsp_frame_end !== w.fend) begin
                  report_mismatch($sformatf("frame_end %0b, expected %0b on byte %02h",
                                            rsp_frame_end, w.fend, w.line));
               end
            end
         end
      end
   end

   task automatic queue_word(input logic [7:0] data, input logic last, input logic seq);
      payload_word_type w;
      w.data = data;
      w.last = last;
      w.seq  = seq;
      pending.push_back(w);
   endtask

   // Waits until every word is taken and every line byte is back, then lets the
   // pipeline run dry.
   task automatic settle();
      while (pending.size() != 0 || req_valid || line_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_address(input logic [7:0] value);
      @(negedge clock);
      csr_valid        <= 1'b1;
      csr_address_byte <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // Frames are mostly short, with a few long ones; the flag and escape values
   // turn up often. A phase may stop in the middle of a frame.
   task automatic queue_random_frames(input int count);
      int n;
      int len;
      int k;
      int pick;
      logic [7:0] data;
      n = 0;
      while (n < count) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
         for (k = 0; k < len && n < count; k++) begin
            pick = $urandom_range(0, 7);
            if (pick == 0) begin
               data = bsfb_pkg::FLAG_BYTE;
            end else if (pick == 1) begin
               data = bsfb_pkg::ESC_BYTE;
            end else begin
               data = 8'($urandom_range(0, 255));
            end
            queue_word(data, k == len - 1, 1'($urandom_range(0, 1)));
            n++;
         end
      end
   endtask

   initial begin : stimulus
      int p;
      logic [7:0] addr;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed words at the reset address first.
      req_max_gap = 3;
      rsp_max_gap = 3;
      queue_word(8'h00, 1'b1, 1'b0);
      queue_word(bsfb_pkg::FLAG_BYTE, 1'b1, 1'b1);
      queue_word(bsfb_pkg::ESC_BYTE, 1'b1, 1'b0);
      // The sequence bit of later words in a frame must have no effect.
      queue_word(8'hFF, 1'b0, 1'b1);
      queue_word(bsfb_pkg::FLAG_BYTE, 1'b0, 1'b0);
      queue_word(bsfb_pkg::ESC_BYTE, 1'b0, 1'b0);
      queue_word(8'h01, 1'b1, 1'b0);
      // Parities that need escaping themselves.
      queue_word(8'h7C, 1'b0, 1'b1);
      queue_word(8'h01, 1'b1, 1'b0);
      queue_word(8'h7F, 1'b0, 1'b0);
      queue_word(8'h01, 1'b1, 1'b1);
      queue_word(8'h55, 1'b0, 1'b1);
      settle();

      // Address changed while a frame is open: it only applies to the next header.
      write_address(8'hFF);
      queue_word(8'hAA, 1'b1, 1'b0);
      queue_word(8'h80, 1'b1, 1'b0);
      settle();
      write_address(8'h00);
      queue_word(8'h12, 1'b1, 1'b1);
      queue_word(bsfb_pkg::FLAG_BYTE, 1'b0, 1'b0);
      queue_word(bsfb_pkg::FLAG_BYTE, 1'b1, 1'b1);
      queue_word(8'hFF, 1'b1, 1'b0);
      settle();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 4)
            0: addr = 8'hFF;
            1: addr = 8'h00;
            default: addr = 8'($urandom_range(0, 255));
         endcase
         write_address(addr);
         req_max_gap = (p % 4 == 2 || p % 4 == 3) ? MAX_WAIT : 0;
         rsp_max_gap = (p % 4 == 1 || p % 4 == 3) ? MAX_WAIT : 0;
         if (p == PRESSURE_PHASE) begin
            req_max_gap = 0;
            rsp_max_gap = 0;
            hold_go = 1'b1;
         end
         queue_random_frames(RANDOM_WORDS);
         settle();
      end

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
